@@ hdl/pru_pkg.sv @@
package pru_pkg;

	// item codes on the input channel
	localparam logic CMD_HEADER = 1'b0;
	localparam logic CMD_PIXEL  = 1'b1;

	// configuration register indexes
	localparam logic REG_ROW_WIDTH    = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [7:0] FILTER_MAX = 8'd4;

	typedef enum logic [2:0] {
		FILT_NONE,
		FILT_SUB,
		FILT_UP,
		FILT_AVG,
		FILT_PAETH
	} filter_t;

	// four channel bytes, channel 0 (red) in the low byte
	typedef logic [3:0][7:0] pixel_t;

	// paeth predictor on one channel byte
	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic signed [9:0] pa;
		logic signed [9:0] pb;
		logic signed [9:0] pc;
		logic [7:0] sel;
		pa = $signed({2'b00, b}) - $signed({2'b00, c});
		pb = $signed({2'b00, a}) - $signed({2'b00, c});
		pc = pa + pb;
		if (pa < 0) pa = -pa;
		if (pb < 0) pb = -pb;
		if (pc < 0) pc = -pc;
		if (pa <= pb && pa <= pc) sel = a;
		else if (pb <= pc) sel = b;
		else sel = c;
		return sel;
	endfunction

endpackage

@@ hdl/pru_ifs.sv @@
// filtered item channel
interface pru_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] filter_type;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	logic [7:0] alpha_in;

	modport source (output valid, cmd, filter_type, red_in, green_in, blue_in, alpha_in,
		input ready);
	modport sink (input valid, cmd, filter_type, red_in, green_in, blue_in, alpha_in,
		output ready);
endinterface

// reconstructed pixel channel
interface pru_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic [7:0] alpha_out;
	logic       row_end;
	logic       image_end;
	logic       bad_filter;

	modport source (output valid, red_out, green_out, blue_out, alpha_out, row_end,
		image_end, bad_filter, input ready);
	modport sink (input valid, red_out, green_out, blue_out, alpha_out, row_end,
		image_end, bad_filter, output ready);
endinterface

@@ hdl/pru_line_store.sv @@
module pru_line_store #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  pru_pkg::pixel_t wdata,
	input  logic           re,
	input  logic [AW-1:0]  raddr,
	output pru_pkg::pixel_t rdata
);

	pru_pkg::pixel_t mem [DEPTH];

	// one write port, one registered read port, read returns old data on a clash
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

@@ hdl/pru_recon.sv @@
module pru_recon (
	input  pru_pkg::filter_t filt,
	input  pru_pkg::pixel_t  filtered,
	input  pru_pkg::pixel_t  left,
	input  pru_pkg::pixel_t  above,
	input  pru_pkg::pixel_t  upper_left,
	output pru_pkg::pixel_t  result
);

	// per-channel prediction and modulo-256 add
	always_comb begin
		logic [7:0] pred;
		logic [8:0] sum;
		result = '0;
		for (int k = 0; k < 4; k++) begin
			sum = {1'b0, left[k]} + {1'b0, above[k]};
			case (filt)
				pru_pkg::FILT_SUB:   pred = left[k];
				pru_pkg::FILT_UP:    pred = above[k];
				pru_pkg::FILT_AVG:   pred = sum[8:1];
				pru_pkg::FILT_PAETH: pred = pru_pkg::paeth(left[k], above[k], upper_left[k]);
				default:             pred = 8'd0;
			endcase
			result[k] = filtered[k] + pred;
		end
	end

endmodule

@@ hdl/png_rgba8_unfilter.sv @@
// PNG row-filter reconstruction for 8-bit RGBA pixels.
// pixels: input channel; cmd selects a row header (filter byte in filter_type)
//   or a pixel (four filtered bytes). A header yields no result.
// results: one reconstructed pixel per input pixel, with row_end, image_end
//   and bad_filter (row filter byte above 4, row passed through unfiltered).
// cfg_we/cfg_index/cfg_data: write row_width (index 0) and image_height
//   (index 1) while the block is idle.
// Throughput: one item per clock while results is ready. The line store is a synchronous
//   memory read at transfer; the prediction works on the compute stage registers and
//   the read data and runs straight into the output register, which drives results.
//   A write and a read of the same column in one cycle are forwarded.
// When results stalls, the output register holds, the compute stage holds,
//   and pixels.ready drops once both are full; nothing is lost.
// Reset: counters clear, the first row sees zeros above, filter is none.
//   The line store is not cleared; its data is only used after the prior row wrote it.
module png_rgba8_unfilter #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [15:0] cfg_data,
	pru_in_if.sink     pixels,
	pru_out_if.source  results
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	// configuration registers
	logic [12:0] row_width_q;
	logic [15:0] image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q    <= 13'd1;
			image_height_q <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				pru_pkg::REG_ROW_WIDTH:    row_width_q <= cfg_data[12:0];
				pru_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage and handshake control
	logic s1_v, s1_go, in_go;
	logic out_v_q;

	assign s1_go = !out_v_q || results.ready;
	assign pixels.ready = !s1_v || s1_go;
	assign in_go = pixels.valid && pixels.ready;

	// position tracking at transfer
	logic [AW-1:0] col_q;
	logic [15:0]   row_q;
	logic          first_q;
	logic [AW-1:0] w_m1, col;
	logic [15:0]   h_m1;
	logic          row_last, image_last;

	always_comb begin
		if (row_width_q == 13'd0) w_m1 = '0;
		else if (32'(row_width_q) > MAX_WIDTH) w_m1 = AW'(MAX_WIDTH - 1);
		else w_m1 = AW'(row_width_q - 13'd1);
		h_m1 = (image_height_q == 16'd0) ? 16'd0 : image_height_q - 16'd1;
		row_last = (col_q >= w_m1);
		col = row_last ? w_m1 : col_q;
		image_last = row_last && (row_q >= h_m1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			first_q <= 1'b1;
		end else if (in_go) begin
			if (pixels.cmd == pru_pkg::CMD_HEADER) begin
				col_q <= '0;
			end else if (row_last) begin
				col_q <= '0;
				if (image_last) begin
					row_q   <= '0;
					first_q <= 1'b1;
				end else begin
					row_q   <= row_q + 16'd1;
					first_q <= 1'b0;
				end
			end else begin
				col_q <= col + AW'(1);
			end
		end
	end

	// compute stage registers
	logic            s1_pix, s1_row_last, s1_image_last, s1_first, s1_fwd;
	logic [7:0]      s1_filter_raw;
	logic [AW-1:0]   s1_col;
	pru_pkg::pixel_t s1_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s1_v <= 1'b0;
		else if (pixels.ready) s1_v <= pixels.valid;
	end

	always_ff @(posedge clk) begin
		if (in_go) begin
			s1_pix        <= (pixels.cmd == pru_pkg::CMD_PIXEL);
			s1_filter_raw <= pixels.filter_type;
			s1_data       <= {pixels.alpha_in, pixels.blue_in, pixels.green_in, pixels.red_in};
			s1_col        <= col;
			s1_row_last   <= row_last;
			s1_image_last <= image_last;
			s1_first      <= first_q;
			// column written by the leaving stage in this same cycle
			s1_fwd        <= s1_v && s1_pix && (s1_col == col);
		end
	end

	// line store of the prior row
	pru_pkg::pixel_t rd_data, result, last_res_q, above;
	logic            wr_en;

	assign wr_en = s1_v && s1_pix && s1_go;

	pru_line_store #(
		.DEPTH(MAX_WIDTH),
		.AW(AW)
	) u_line_store (
		.clk(clk),
		.we(wr_en),
		.waddr(s1_col),
		.wdata(result),
		.re(in_go),
		.raddr(col),
		.rdata(rd_data)
	);

	// row filter state, left and upper-left pixels, updated in item order
	pru_pkg::filter_t filt_q;
	logic             bad_q;
	pru_pkg::pixel_t  left_q, ul_q;

	always_comb begin
		if (s1_first) above = '0;
		else if (s1_fwd) above = last_res_q;
		else above = rd_data;
	end

	pru_recon u_recon (
		.filt(filt_q),
		.filtered(s1_data),
		.left(left_q),
		.above(above),
		.upper_left(ul_q),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= pru_pkg::FILT_NONE;
			bad_q  <= 1'b0;
			left_q <= '0;
			ul_q   <= '0;
		end else if (s1_v && s1_go) begin
			if (!s1_pix) begin
				if (s1_filter_raw > pru_pkg::FILTER_MAX) begin
					filt_q <= pru_pkg::FILT_NONE;
					bad_q  <= 1'b1;
				end else begin
					filt_q <= pru_pkg::filter_t'(s1_filter_raw[2:0]);
					bad_q  <= 1'b0;
				end
				left_q <= '0;
				ul_q   <= '0;
			end else if (s1_row_last) begin
				left_q <= '0;
				ul_q   <= '0;
			end else begin
				left_q <= result;
				ul_q   <= above;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) last_res_q <= result;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (s1_go) out_v_q <= s1_v && s1_pix;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			results.red_out    <= result[0];
			results.green_out  <= result[1];
			results.blue_out   <= result[2];
			results.alpha_out  <= result[3];
			results.row_end    <= s1_row_last;
			results.image_end  <= s1_image_last;
			results.bad_filter <= bad_q;
		end
	end

	assign results.valid = out_v_q;

	// checks
	a_hdr_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v && !s1_pix && s1_go |=> !out_v_q)
		else $error("row header produced a result");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pixels.ready |-> s1_v && out_v_q)
		else $error("input stalled with a free stage");

	a_image_end_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> !results.image_end || results.row_end)
		else $error("image end without row end");

	a_row_clears_left: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && s1_row_last |=> left_q == '0 && ul_q == '0)
		else $error("left pixel not cleared at row end");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

	localparam int MAX_W         = 4096;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 6;

	typedef struct packed {
		logic            cmd;
		logic [7:0]      ftype;
		pru_pkg::pixel_t px;
	} pix_item_t;

	typedef struct packed {
		pru_pkg::pixel_t px;
		logic            row_end;
		logic            image_end;
		logic            bad_filter;
	} pix_result_t;

	// reconstruction predictor and queue of expected pixels
	class pixel_scoreboard;
		pru_pkg::pixel_t  line_mem [MAX_W];
		pru_pkg::pixel_t  left_px;
		pru_pkg::pixel_t  upleft_px;
		int               col_cnt;
		logic [15:0]      row_cnt;
		pru_pkg::filter_t row_filt;
		bit               first_row;
		bit               bad_row;
		logic [12:0]      width_reg;
		logic [15:0]      height_reg;
		pix_result_t      expected_pixels [$];
		int unsigned      errors;

		function new();
			left_px    = '0;
			upleft_px  = '0;
			col_cnt    = 0;
			row_cnt    = '0;
			row_filt   = pru_pkg::FILT_NONE;
			first_row  = 1'b1;
			bad_row    = 1'b0;
			width_reg  = 13'd1;
			height_reg = 16'd1;
			errors     = 0;
		endfunction

		function void set_reg(logic idx, logic [pru_pkg::CFG_DATA_W-1:0] v);
			if (idx == pru_pkg::REG_ROW_WIDTH) begin
				width_reg = v[12:0];
			end else begin
				height_reg = v[15:0];
			end
		endfunction

		// zero acts as one, oversize saturates to the store depth
		function int eff_width();
			if (width_reg == 0) return 1;
			if (width_reg > MAX_W) return MAX_W;
			return int'(width_reg);
		endfunction

		function int column();
			return col_cnt;
		endfunction

		function bit at_image_start();
			return first_row && row_cnt == 0 && col_cnt == 0;
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		function logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
			int ia, ib, ic, p, da, db, dc;
			ia = a;
			ib = b;
			ic = c;
			p  = ia + ib - ic;
			da = p - ia;
			db = p - ib;
			dc = p - ic;
			if (da < 0) da = -da;
			if (db < 0) db = -db;
			if (dc < 0) dc = -dc;
			if (da <= db && da <= dc) return a;
			if (db <= dc) return b;
			return c;
		endfunction

		function logic [7:0] predict_byte(logic [7:0] a, logic [7:0] b, logic [7:0] c);
			logic [8:0] sum;
			case (row_filt)
				pru_pkg::FILT_SUB: return a;
				pru_pkg::FILT_UP: return b;
				pru_pkg::FILT_AVG: begin
					sum = a + b;
					return sum[8:1];
				end
				pru_pkg::FILT_PAETH: return paeth_pick(a, b, c);
				default: return 8'h00;
			endcase
		endfunction

		// update the model on an accepted item, queue the pixel it yields
		function void take_item(pix_item_t it);
			int unsigned w, h;
			int col;
			pru_pkg::pixel_t above, res;
			pix_result_t want;
			if (it.cmd == pru_pkg::CMD_HEADER) begin
				if (it.ftype > pru_pkg::FILTER_MAX) begin
					row_filt = pru_pkg::FILT_NONE;
					bad_row  = 1'b1;
				end else begin
					row_filt = pru_pkg::filter_t'(it.ftype[2:0]);
					bad_row  = 1'b0;
				end
				col_cnt   = 0;
				left_px   = '0;
				upleft_px = '0;
				return;
			end
			w = eff_width();
			h = (height_reg == 0) ? 1 : height_reg;
			col = (col_cnt >= w) ? w - 1 : col_cnt;
			above = first_row ? '0 : line_mem[col];
			for (int k = 0; k < 4; k++)
				res[k] = it.px[k] + predict_byte(left_px[k], above[k], upleft_px[k]);
			line_mem[col] = res;
			left_px   = res;
			upleft_px = above;

			want.px         = res;
			want.row_end    = (col >= w - 1);
			want.image_end  = want.row_end && (row_cnt >= h - 1);
			want.bad_filter = bad_row;
			expected_pixels.push_back(want);

			// row and image bookkeeping
			if (want.row_end) begin
				col_cnt   = 0;
				left_px   = '0;
				upleft_px = '0;
				if (want.image_end) begin
					row_cnt   = '0;
					first_row = 1'b1;
				end else begin
					row_cnt++;
					first_row = 1'b0;
				end
			end else begin
				col_cnt = col + 1;
			end
		endfunction

		function void report(string what, pix_result_t want, pix_result_t got);
			errors++;
			if (errors <= 10)
				$display("%0t %s: exp %h re %b ie %b bad %b, got %h re %b ie %b bad %b",
					$time, what, want.px, want.row_end, want.image_end, want.bad_filter,
					got.px, got.row_end, got.image_end, got.bad_filter);
		endfunction

		function void check_pixel(pix_result_t got);
			pix_result_t want;
			if (expected_pixels.size() == 0) begin
				report("unexpected pixel", '0, got);
				return;
			end
			want = expected_pixels.pop_front();
			if (got.px !== want.px || got.row_end !== want.row_end ||
					got.image_end !== want.image_end || got.bad_filter !== want.bad_filter)
				report("pixel mismatch", want, got);
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic                           cfg_index;
	logic [pru_pkg::CFG_DATA_W-1:0] cfg_data;

	pru_in_if  in_if ();
	pru_out_if out_if ();

	pixel_scoreboard sb;
	int burst_left;
	int items_sent;
	int idle_cycles = 0;
	int pat_left = 0;
	logic [15:0] stall_pat;

	png_rgba8_unfilter #(
		.MAX_WIDTH (MAX_W)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (in_if),
		.results   (out_if)
	);

	always #5 clk = ~clk;

	// result-side stall pattern, rotated each clock and redrawn when its countdown runs out
	always @(posedge clk) begin
		if (pat_left == 0) begin
			pat_left = 64;
			case ($urandom_range(0, 3))
				0: stall_pat = '1;
				1: stall_pat = 16'($urandom) | 16'h0001;
				2: stall_pat = 16'($urandom & $urandom & $urandom) | 16'h0001;
				default: stall_pat = 16'($urandom | $urandom);
			endcase
		end
		out_if.ready <= stall_pat[0];
		stall_pat = {stall_pat[0], stall_pat[15:1]};
		pat_left--;
	end

	// check every result transfer
	always @(posedge clk) begin
		pix_result_t got;
		if (arst_n && out_if.valid && out_if.ready) begin
			got = {out_if.alpha_out, out_if.blue_out, out_if.green_out, out_if.red_out,
				out_if.row_end, out_if.image_end, out_if.bad_filter};
			sb.check_pixel(got);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'($urandom_range(0, 3));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic pru_pkg::pixel_t rand_pixel();
		pru_pkg::pixel_t p;
		for (int k = 0; k < 4; k++)
			p[k] = rand_byte();
		return p;
	endfunction

	// one input transfer, with bursts and gaps on the sender side
	task automatic send_item(input pix_item_t it);
		int gap;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
		end
		in_if.valid       <= 1'b1;
		in_if.cmd         <= it.cmd;
		in_if.filter_type <= it.ftype;
		in_if.red_in      <= it.px[0];
		in_if.green_in    <= it.px[1];
		in_if.blue_in     <= it.px[2];
		in_if.alpha_in    <= it.px[3];
		do @(posedge clk); while (!in_if.ready);
		sb.take_item(it);
		items_sent++;
		burst_left--;
	endtask

	task automatic send_header(input logic [7:0] f);
		pix_item_t it;
		it.cmd   = pru_pkg::CMD_HEADER;
		it.ftype = f;
		it.px    = rand_pixel();
		send_item(it);
	endtask

	task automatic send_pixel(input pru_pkg::pixel_t p);
		pix_item_t it;
		it.cmd   = pru_pkg::CMD_PIXEL;
		it.ftype = 8'($urandom);
		it.px    = p;
		send_item(it);
	endtask

	task automatic finish_row();
		do send_pixel(rand_pixel()); while (sb.column() != 0);
	endtask

	// one row: header variants, random pixels, sometimes a restart in mid-row
	task automatic send_row();
		int cut;
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 15) begin
			send_header(8'($urandom_range(0, 4)));
		end else if (pick < 18) begin
			send_header(8'($urandom_range(5, 255)));
		end else if (pick == 18) begin
			send_header(8'($urandom));
			send_header(8'($urandom_range(0, 4)));
		end
		cut = -1;
		if (sb.eff_width() > 1 && $urandom_range(0, 9) == 0)
			cut = $urandom_range(1, sb.eff_width() - 1);
		do begin
			if (sb.column() == cut) begin
				send_header(8'($urandom_range(0, 4)));
				cut = -1;
			end
			send_pixel(rand_pixel());
		end while (sb.column() != 0);
	endtask

	// stop sending and let every pending pixel come out
	task automatic wait_drained();
		in_if.valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [pru_pkg::CFG_DATA_W-1:0] v);
		cfg_index <= idx;
		cfg_data  <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	// upper bits above the 13-bit field are don't-care
	task automatic set_width(input int w);
		write_reg(pru_pkg::REG_ROW_WIDTH, {3'($urandom_range(0, 7)), 13'(w)});
	endtask

	task automatic run_images(input int w, input int h, input int count);
		int goal;
		wait_drained();
		set_width(w);
		write_reg(pru_pkg::REG_IMAGE_HEIGHT, pru_pkg::CFG_DATA_W'(h));
		goal = items_sent + count;
		while (items_sent < goal || !sb.at_image_start())
			send_row();
	endtask

	initial begin
		int goal;
		sb = new();
		clk               = 1'b0;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = pru_pkg::REG_ROW_WIDTH;
		cfg_data          = '0;
		in_if.valid       = 1'b0;
		in_if.cmd         = pru_pkg::CMD_HEADER;
		in_if.filter_type = '0;
		in_if.red_in      = '0;
		in_if.green_in    = '0;
		in_if.blue_in     = '0;
		in_if.alpha_in    = '0;
		burst_left        = 0;
		items_sent        = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// pixel ahead of any header passes unfiltered as a one-pixel image
		send_pixel(32'hFF_FF_FF_FF);
		wait_drained();
		set_width(2);
		write_reg(pru_pkg::REG_IMAGE_HEIGHT, 16'd4);

		// one image through none, sub, up and average
		send_header(8'(pru_pkg::FILT_NONE));
		send_pixel(32'h80_7F_01_FF);
		send_pixel(32'hFF_00_FF_01);
		send_header(8'(pru_pkg::FILT_SUB));
		send_pixel(32'hFF_FF_FF_FF);
		send_pixel(32'h01_01_01_01);
		send_header(8'(pru_pkg::FILT_UP));
		send_pixel(32'h01_02_FE_FF);
		send_pixel(32'hFF_FF_00_80);
		send_header(8'(pru_pkg::FILT_AVG));
		send_pixel(32'hFF_00_FF_00);
		send_pixel(32'h7F_80_81_FF);

		// paeth on first and second rows, then bad filter bytes
		send_header(8'(pru_pkg::FILT_PAETH));
		send_pixel(32'hFF_00_80_7F);
		send_pixel(32'h10_F0_01_FF);
		send_header(8'(pru_pkg::FILT_PAETH));
		send_pixel(32'h00_FF_FF_00);
		send_pixel(32'hFE_01_7F_80);
		send_header(8'hFF);
		send_pixel(32'hAA_55_AA_55);
		// header in mid-row restarts the row
		send_header(8'h05);
		send_pixel(32'h12_34_56_78);
		send_pixel(32'h9A_BC_DE_F0);
		// no header: the bad filter carries over
		send_pixel(32'hFF_FF_FF_FF);
		send_pixel(32'h00_00_00_00);

		run_images(5, 3, 300);

		// tallest image, cut short by lowering the height in mid-row
		wait_drained();
		set_width(9);
		write_reg(pru_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
		goal = items_sent + 150;
		while (items_sent < goal)
			send_row();
		send_header(8'(pru_pkg::FILT_UP));
		repeat (4) send_pixel(rand_pixel());
		wait_drained();
		write_reg(pru_pkg::REG_IMAGE_HEIGHT, 16'd0);
		finish_row();
		while (!sb.at_image_start())
			send_row();

		run_images(1, 4, 150);

		// width shrinks below the current column in mid-row
		wait_drained();
		set_width(20);
		write_reg(pru_pkg::REG_IMAGE_HEIGHT, 16'd3);
		send_header(8'(pru_pkg::FILT_PAETH));
		finish_row();
		send_header(8'(pru_pkg::FILT_SUB));
		repeat (12) send_pixel(rand_pixel());
		wait_drained();
		set_width(5);
		finish_row();
		while (!sb.at_image_start())
			send_row();

		run_images(0, 0, 100);

		// oversize width, then a shrink ends the row
		wait_drained();
		set_width(8191);
		write_reg(pru_pkg::REG_IMAGE_HEIGHT, 16'd1);
		send_header(8'(pru_pkg::FILT_AVG));
		repeat (40) send_pixel(rand_pixel());
		wait_drained();
		set_width(3);
		finish_row();

		run_images(3, 2, 250);
		run_images(17, 5, 300);
		run_images(64, 3, 150);

		wait_drained();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
